>>> rtl/core/hrbc_pkg.sv
// Shared types and constants for the brake current control core.
package hrbc_pkg;

  localparam int unsigned SpeedW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ErpmW  = 19;
  localparam int unsigned CurW   = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned RampW  = 10;
  localparam int unsigned ErrW   = 15;
  localparam int unsigned DtW    = 7;

  localparam logic [TimeW-1:0]         OdomTimeoutMs = 32'd200;
  localparam logic signed [17:0]       ErpmGainQ8    = 18'sd1181;
  localparam logic signed [17:0]       ErpmOffset    = 18'sd0;
  localparam logic [DtW-1:0]           FirstDtMs     = 7'd20;
  localparam logic [DtW-1:0]           DtMinMs       = 7'd1;
  localparam logic [DtW-1:0]           DtMaxMs       = 7'd100;
  localparam logic [CurW-1:0]          HardLimitMa   = 16'd50000;
  localparam logic signed [ErpmW-1:0]  ErpmMax       = 19'sd262143;
  localparam logic signed [ErpmW-1:0]  ErpmMin       = -19'sd262144;

  typedef enum logic [2:0] {
    CFG_BRAKE_ENABLE   = 3'd0,
    CFG_CURRENT_MAX    = 3'd1,
    CFG_CURRENT_START  = 3'd2,
    CFG_CURRENT_GAIN   = 3'd3,
    CFG_RAMP           = 3'd4,
    CFG_ENGAGE_ERROR   = 3'd5,
    CFG_RELEASE_ERROR  = 3'd6,
    CFG_RELEASE_SPEED  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    KIND_ODOM    = 1'b0,
    KIND_COMMAND = 1'b1
  } kind_e;

  typedef struct packed {
    logic             brake_enable;
    logic [CurW-1:0]  current_max_ma;
    logic [CurW-1:0]  current_start_ma;
    logic [CfgW-1:0]  current_gain_q8;
    logic [RampW-1:0] ramp_ma_per_ms;
    logic [ErrW-1:0]  engage_error_mm_s;
    logic [ErrW-1:0]  release_error_mm_s;
    logic [ErrW-1:0]  release_speed_mm_s;
  } cfg_t;

  typedef struct packed {
    logic [SpeedW-1:0] measured_speed;
    logic              odom_seen;
    logic [TimeW-1:0]  last_odom_ms;
    logic              command_seen;
    logic [TimeW-1:0]  last_command_ms;
    logic              braking_now;
    logic [CurW-1:0]   present_current;
  } state_t;

  typedef struct packed {
    logic             brake_mode;
    logic [ErpmW-1:0] erpm_command;
    logic [CurW-1:0]  brake_current_ma;
  } result_t;

endpackage

>>> rtl/core/hrbc_cfg.sv
// Configuration register file of the brake current control core.
module hrbc_cfg
  import hrbc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_enable       <= 1'b1;
      cfg_q.current_max_ma     <= 16'd10000;
      cfg_q.current_start_ma   <= 16'd5000;
      cfg_q.current_gain_q8    <= 16'd2560;
      cfg_q.ramp_ma_per_ms     <= 10'd100;
      cfg_q.engage_error_mm_s  <= 15'd150;
      cfg_q.release_error_mm_s <= 15'd50;
      cfg_q.release_speed_mm_s <= 15'd150;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BRAKE_ENABLE:  cfg_q.brake_enable       <= cfg_data_i[0];
        CFG_CURRENT_MAX:   cfg_q.current_max_ma     <= cfg_data_i;
        CFG_CURRENT_START: cfg_q.current_start_ma   <= cfg_data_i;
        CFG_CURRENT_GAIN:  cfg_q.current_gain_q8    <= cfg_data_i;
        CFG_RAMP:          cfg_q.ramp_ma_per_ms     <= cfg_data_i[RampW-1:0];
        CFG_ENGAGE_ERROR:  cfg_q.engage_error_mm_s  <= cfg_data_i[ErrW-1:0];
        CFG_RELEASE_ERROR: cfg_q.release_error_mm_s <= cfg_data_i[ErrW-1:0];
        CFG_RELEASE_SPEED: cfg_q.release_speed_mm_s <= cfg_data_i[ErrW-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/hrbc_calc.sv
// Single-pass decision, brake current ramp and erpm conversion for one item.
module hrbc_calc
  import hrbc_pkg::*;
(
  input  logic              kind_i,
  input  logic [SpeedW-1:0] speed_mm_s_i,
  input  logic [TimeW-1:0]  time_ms_i,
  input  cfg_t              cfg_i,
  input  state_t            st_i,
  output logic              has_result_o,
  output result_t           res_o,
  output state_t            st_o
);

  logic signed [17:0] ms;
  logic signed [17:0] sp;
  logic signed [17:0] act_abs;
  logic signed [17:0] tgt_abs;
  logic signed [17:0] err;
  logic               above_release;
  logic               opposite;
  logic               dir_change;
  logic               fresh;
  logic               want;
  logic [TimeW-1:0]   odom_age;
  logic [TimeW-1:0]   cmd_gap;
  logic [DtW-1:0]     dt;
  logic [CurW-1:0]    ceil_ma;
  logic [CurW-1:0]    start_ma;
  logic [16:0]        cerr;
  logic [32:0]        gprod;
  logic [25:0]        target_raw;
  logic [CurW-1:0]    target;
  logic [16:0]        step;
  logic [17:0]        up_sum;
  logic [17:0]        dn_lim;
  logic [CurW-1:0]    new_cur;
  logic signed [33:0] eprod;
  logic signed [35:0] erpm_full;

  always_comb begin
    ms       = 18'($signed(st_i.measured_speed));
    sp       = 18'($signed(speed_mm_s_i));
    act_abs  = (ms < 0) ? -ms : ms;
    tgt_abs  = (sp < 0) ? -sp : sp;
    err      = act_abs - tgt_abs;
    above_release = act_abs > $signed({3'b000, cfg_i.release_speed_mm_s});
    opposite = (ms > 0 && sp < 0) || (ms < 0 && sp > 0);
    dir_change = above_release && opposite;
    odom_age = time_ms_i - st_i.last_odom_ms;
    fresh    = st_i.odom_seen && (odom_age <= OdomTimeoutMs);
    want = cfg_i.brake_enable && fresh && above_release &&
           (dir_change || err > $signed({3'b000, cfg_i.engage_error_mm_s}) ||
            (st_i.braking_now && err > $signed({3'b000, cfg_i.release_error_mm_s})));

    cmd_gap = time_ms_i - st_i.last_command_ms;
    if (!st_i.command_seen) begin
      dt = FirstDtMs;
    end else if (cmd_gap < TimeW'(DtMinMs)) begin
      dt = DtMinMs;
    end else if (cmd_gap > TimeW'(DtMaxMs)) begin
      dt = DtMaxMs;
    end else begin
      dt = cmd_gap[DtW-1:0];
    end

    ceil_ma  = (cfg_i.current_max_ma > HardLimitMa) ? HardLimitMa : cfg_i.current_max_ma;
    start_ma = (cfg_i.current_start_ma > ceil_ma) ? ceil_ma : cfg_i.current_start_ma;
    if (dir_change) begin
      cerr = act_abs[16:0];
    end else if (err > 0) begin
      cerr = err[16:0];
    end else begin
      cerr = '0;
    end
    gprod      = 33'(cfg_i.current_gain_q8) * 33'(cerr);
    target_raw = 26'(start_ma) + 26'(gprod[32:8]);
    target     = (target_raw > 26'(ceil_ma)) ? ceil_ma : target_raw[CurW-1:0];

    step   = 17'(cfg_i.ramp_ma_per_ms) * 17'(dt);
    up_sum = 18'(st_i.present_current) + 18'(step);
    dn_lim = 18'(target) + 18'(step);
    if (target > st_i.present_current) begin
      new_cur = (up_sum < 18'(target)) ? up_sum[CurW-1:0] : target;
    end else begin
      new_cur = (18'(st_i.present_current) > dn_lim) ?
                CurW'(18'(st_i.present_current) - 18'(step)) : target;
    end

    eprod     = 34'(ErpmGainQ8) * 34'(sp);
    erpm_full = ((36'(eprod) + 36'sd128) >>> 8) + 36'(ErpmOffset);

    st_o         = st_i;
    res_o        = '0;
    has_result_o = 1'b0;
    if (kind_i == KIND_ODOM) begin
      st_o.measured_speed = speed_mm_s_i;
      st_o.odom_seen      = 1'b1;
      st_o.last_odom_ms   = time_ms_i;
    end else begin
      has_result_o         = 1'b1;
      st_o.command_seen    = 1'b1;
      st_o.last_command_ms = time_ms_i;
      if (want) begin
        st_o.braking_now       = 1'b1;
        st_o.present_current   = new_cur;
        res_o.brake_mode       = 1'b1;
        res_o.brake_current_ma = new_cur;
      end else begin
        st_o.braking_now     = 1'b0;
        st_o.present_current = '0;
        if (erpm_full > 36'(ErpmMax)) begin
          res_o.erpm_command = ErpmMax;
        end else if (erpm_full < 36'(ErpmMin)) begin
          res_o.erpm_command = ErpmMin;
        end else begin
          res_o.erpm_command = erpm_full[ErpmW-1:0];
        end
      end
    end
  end

endmodule

>>> rtl/core/hysteretic_ramped_brake_current_control_core.sv
// Top level of the hysteretic ramped brake current control core.
// Takes one item per cycle while the output does not stall: each transfer is registered in
// the input register and processed against the controller state, and a drive command's
// result is then registered in the result register; odometry samples yield none. The state
// update (braking flag, present current, timestamps) is computed combinationally from the
// input register and registered as the item advances. Output stalls back up into the input
// only when both the input register and the result register are full.
module hysteretic_ramped_brake_current_control_core
  import hrbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_kind_i,
  input  logic [SpeedW-1:0] in_speed_mm_s_i,
  input  logic [TimeW-1:0]  in_time_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              out_brake_mode_o,
  output logic [ErpmW-1:0]  out_erpm_command_o,
  output logic [CurW-1:0]   out_brake_current_ma_o
);

  cfg_t              cfg;
  state_t            st_q;
  state_t            st_d;
  result_t           res_d;
  result_t           res_q;
  logic              has_result;
  logic              s1_valid_q;
  logic              s1_kind_q;
  logic [SpeedW-1:0] s1_speed_q;
  logic [TimeW-1:0]  s1_time_q;
  logic              out_valid_q;
  logic              s1_adv;
  logic              in_xfer;
  logic              out_xfer;

  hrbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hrbc_calc u_calc (
    .kind_i       (s1_kind_q),
    .speed_mm_s_i (s1_speed_q),
    .time_ms_i    (s1_time_q),
    .cfg_i        (cfg),
    .st_i         (st_q),
    .has_result_o (has_result),
    .res_o        (res_d),
    .st_o         (st_d)
  );

  assign out_xfer   = out_valid_q && !out_stall_i;
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q  <= in_kind_i;
      s1_speed_q <= in_speed_mm_s_i;
      s1_time_q  <= in_time_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (s1_adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && has_result) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_brake_mode_o       = res_q.brake_mode;
  assign out_erpm_command_o     = res_q.erpm_command;
  assign out_brake_current_ma_o = res_q.brake_current_ma;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled without a blocked item");
  a_brake_no_erpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_brake_mode_o) |-> (out_erpm_command_o == '0))
    else $error("erpm nonzero in brake mode");
  a_speed_no_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_brake_mode_o) |-> (out_brake_current_ma_o == '0))
    else $error("current nonzero in speed mode");
  a_current_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_brake_current_ma_o <= HardLimitMa))
    else $error("brake current above hard limit");
  a_idle_current_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.braking_now |-> (st_q.present_current == '0))
    else $error("present current held while not braking");
`endif

endmodule
